// File: design/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared widths and types for the 4x4 fixed point matrix inverter.
// ----------------------------------------------------------------------------
package mi4_pkg;

  // element format
  localparam int ELEM_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int MAT_DEPTH  = 16;
  localparam int IDX_W      = $clog2(MAT_DEPTH);

  // intermediate widths, all exact
  localparam int PROD_W  = 2 * ELEM_WIDTH;          // 2-element product
  localparam int TERM_W  = 3 * ELEM_WIDTH;          // 3-element product
  localparam int ADJ_W   = TERM_W + 2;              // sum of six terms
  localparam int DPROD_W = ADJ_W + ELEM_WIDTH;      // cofactor times element
  localparam int DET_W   = DPROD_W + 1;             // sum of four of those

  // divider widths
  localparam int Q_W     = ELEM_WIDTH + 1;          // quotient bits kept
  localparam int REM_W   = DET_W + Q_W + 1;
  localparam int CNT_W   = $clog2(Q_W + 1);
  localparam int NUM_SH  = 2 * FRAC_BITS + 1;       // scale, doubled for rounding

  // stream widths
  localparam int TDATA_W = ((ELEM_WIDTH + IDX_W + 7) / 8) * 8;
  localparam int TUSER_W = 2;

  // divider status back to the sequencer
  typedef struct packed {
    logic           done;
    logic           big;
    logic [Q_W-1:0] quot;
  } div_res_t;

endpackage

// File: design/mi4_ram.sv
// ----------------------------------------------------------------------------
// mi4_ram
// Generic single port RAM, synchronous write, registered read.
// ----------------------------------------------------------------------------
module mi4_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/mi4_divider.sv
// ----------------------------------------------------------------------------
// mi4_divider
// Bit-serial restoring divider: floor((2n*2^(2F) + d) / 2d), one bit a cycle,
// with an overflow check in the first step.
// ----------------------------------------------------------------------------
module mi4_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mi4_pkg::ADJ_W-1:0]   mag,
  input  logic [mi4_pkg::DET_W-1:0]   dmag,
  output mi4_pkg::div_res_t           res
);

  logic [mi4_pkg::REM_W-1:0] rem;
  logic [mi4_pkg::REM_W-1:0] dsh;
  logic [mi4_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic                      ge;

  assign ge = (rem >= dsh);

  // first step only tests for a quotient too wide, then one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        rem      <= (mi4_pkg::REM_W'(mag) << mi4_pkg::NUM_SH) + mi4_pkg::REM_W'(dmag);
        dsh      <= mi4_pkg::REM_W'(dmag) << (mi4_pkg::Q_W + 1);
        cnt      <= mi4_pkg::CNT_W'(mi4_pkg::Q_W);
        busy     <= 1'b1;
        res.quot <= '0;
        res.big  <= 1'b0;
      end else if (busy) begin
        if (cnt == mi4_pkg::CNT_W'(mi4_pkg::Q_W)) begin
          res.big <= ge;
        end else begin
          if (ge) begin
            rem <= rem - dsh;
          end
          res.quot <= {res.quot[mi4_pkg::Q_W-2:0], ge};
        end
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy     <= 1'b0;
          res.done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// File: design/matrix4_inverse.sv
// ----------------------------------------------------------------------------
// matrix4_inverse
// 4x4 matrix inverse by cofactors, signed fixed point, streaming in and out.
// ----------------------------------------------------------------------------
// Elements are loaded one per cycle while the block is idle into a 16-entry
// memory, each tagged with its row-major index; index 15 starts an inversion
// of the stored matrix. The 16 cofactors are built one triple product at a
// time through the single read port of the element memory (states S_TX, S_TY,
// S_TZ and S_TACC per term, 6 terms a cofactor) and kept in a second memory,
// with the determinant gathered along the way. Each of the 16 results then
// fetches its cofactor (S_DRD) and, unless the determinant is zero, starts
// the bit-serial divider (S_DST) and waits on its 18 steps (S_DWAIT); it then
// holds in S_OUT until the output transaction is taken, so output stalls
// lengthen an inversion. No input is taken until the last result has gone.
// A zero determinant gives zero results flagged singular; quotients outside
// the element range are clipped and flagged saturated. The stored matrix is
// kept, so a new index-15 transaction inverts it with that element replaced.
module matrix4_inverse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [mi4_pkg::TDATA_W-1:0] s_tdata,  // element_value, element_index
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mi4_pkg::TDATA_W-1:0] m_tdata,  // result_value, result_index
  output logic [mi4_pkg::TUSER_W-1:0] m_tuser,  // singular, saturated
  output logic                        m_tlast   // last_result
);

  localparam int EW = mi4_pkg::ELEM_WIDTH;
  localparam int IW = mi4_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_TX, S_TY, S_TZ, S_TACC, S_CWR, S_DMUL, S_DADD,
    S_DPREP, S_DRD, S_DST, S_DWAIT, S_OUT
  } state_t;

  state_t                            state;
  logic [IW-1:0]                     k;
  logic [2:0]                        t;
  logic signed [EW-1:0]              xval;
  logic signed [mi4_pkg::PROD_W-1:0] pval;
  logic signed [mi4_pkg::ADJ_W-1:0]  acc;
  logic signed [mi4_pkg::DPROD_W-1:0] dprod;
  logic signed [mi4_pkg::DET_W-1:0]  det;
  logic [mi4_pkg::DET_W-1:0]         dmag;
  logic                              dneg;
  logic                              dzero;
  logic                              rneg;
  logic [mi4_pkg::ADJ_W-1:0]         amag;

  logic                              in_acc;
  logic [IW-1:0]                     in_idx;
  logic [IW-1:0]                     e_addr;
  logic [IW-1:0]                     rd_addr;
  logic [EW-1:0]                     e_rdata;
  logic signed [EW-1:0]              ev;
  logic [mi4_pkg::ADJ_W-1:0]         a_rdata;
  logic signed [mi4_pkg::ADJ_W-1:0]  av;
  logic signed [mi4_pkg::TERM_W-1:0] term;
  logic                              term_neg;
  logic [1:0]                        row_k;
  logic [1:0]                        col_k;
  logic                              div_start;
  mi4_pkg::div_res_t                 div_res;
  logic [mi4_pkg::Q_W-1:0]           lim;
  logic                              sat;
  logic [EW-1:0]                     qv;

  // position of the i-th kept line when line skip is removed
  function automatic logic [1:0] skip_map(input logic [1:0] skip, input logic [1:0] i);
    skip_map = (i < skip) ? i : i + 2'd1;
  endfunction

  // column chosen by row i in permutation t of three
  function automatic logic [1:0] perm_col(input logic [2:0] tt, input logic [1:0] i);
    logic [5:0] p;
    unique case (tt)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd1, 2'd2, 2'd0};
      3'd2:    p = {2'd2, 2'd0, 2'd1};
      3'd3:    p = {2'd0, 2'd2, 2'd1};
      3'd4:    p = {2'd1, 2'd0, 2'd2};
      3'd5:    p = {2'd0, 2'd1, 2'd2};
      default: p = '0;
    endcase
    perm_col = p[2*i +: 2];
  endfunction

  // odd permutations
  function automatic logic perm_odd(input logic [2:0] tt);
    perm_odd = (tt == 3'd1) || (tt == 3'd2) || (tt == 3'd5);
  endfunction

  assign row_k    = k[3:2];
  assign col_k    = k[1:0];
  assign in_idx   = s_tdata[EW +: IW];
  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE) && !rst;
  assign ev       = e_rdata;
  assign av       = a_rdata;
  assign term     = mi4_pkg::TERM_W'(pval) * mi4_pkg::TERM_W'(ev);
  assign term_neg = perm_odd(t) ^ row_k[0] ^ col_k[0];
  assign amag     = av[mi4_pkg::ADJ_W-1] ? mi4_pkg::ADJ_W'(-av) : a_rdata;
  assign div_start = (state == S_DST) && !dzero;

  // element read address: minor of row col_k, column row_k (transposed)
  always_comb begin
    unique case (state)
      S_TX:    rd_addr = {skip_map(col_k, 2'd0), skip_map(row_k, perm_col(t, 2'd0))};
      S_TY:    rd_addr = {skip_map(col_k, 2'd1), skip_map(row_k, perm_col(t, 2'd1))};
      S_TZ:    rd_addr = {skip_map(col_k, 2'd2), skip_map(row_k, perm_col(t, 2'd2))};
      S_CWR:   rd_addr = {2'd0, row_k};
      default: rd_addr = '0;
    endcase
  end

  assign e_addr = in_acc ? in_idx : rd_addr;

  // clipping of the quotient
  always_comb begin
    lim = rneg ? mi4_pkg::Q_W'(1) << (EW - 1) : (mi4_pkg::Q_W'(1) << (EW - 1)) - 1'b1;
    sat = div_res.big || (div_res.quot > lim);
    qv  = sat ? lim[EW-1:0] : div_res.quot[EW-1:0];
  end

  mi4_ram #(.WIDTH(EW), .DEPTH(mi4_pkg::MAT_DEPTH)) u_elem_ram (
    .clk   (clk),
    .we    (in_acc),
    .addr  (e_addr),
    .wdata (s_tdata[EW-1:0]),
    .rdata (e_rdata)
  );

  mi4_ram #(.WIDTH(mi4_pkg::ADJ_W), .DEPTH(mi4_pkg::MAT_DEPTH)) u_adj_ram (
    .clk   (clk),
    .we    (state == S_CWR),
    .addr  (k),
    .wdata (acc),
    .rdata (a_rdata)
  );

  mi4_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (amag),
    .dmag  (dmag),
    .res   (div_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc && (in_idx == IW'(mi4_pkg::MAT_DEPTH - 1))) begin
            k     <= '0;
            t     <= '0;
            acc   <= '0;
            det   <= '0;
            state <= S_TX;
          end
        end
        S_TX: state <= S_TY;
        S_TY: begin
          xval  <= ev;
          state <= S_TZ;
        end
        S_TZ: begin
          pval  <= mi4_pkg::PROD_W'(xval) * mi4_pkg::PROD_W'(ev);
          state <= S_TACC;
        end
        S_TACC: begin
          acc <= term_neg ? acc - mi4_pkg::ADJ_W'(term) : acc + mi4_pkg::ADJ_W'(term);
          if (t == 3'd5) begin
            t     <= '0;
            state <= S_CWR;
          end else begin
            t     <= t + 3'd1;
            state <= S_TX;
          end
        end
        S_CWR: begin
          // cofactors of row zero (adjugate column zero) feed the determinant
          if (col_k == 2'd0) begin
            state <= S_DMUL;
          end else begin
            acc <= '0;
            if (k == IW'(mi4_pkg::MAT_DEPTH - 1)) begin
              k     <= '0;
              state <= S_DPREP;
            end else begin
              k     <= k + 1'b1;
              state <= S_TX;
            end
          end
        end
        S_DMUL: begin
          dprod <= mi4_pkg::DPROD_W'(acc) * mi4_pkg::DPROD_W'(ev);
          state <= S_DADD;
        end
        S_DADD: begin
          det   <= det + mi4_pkg::DET_W'(dprod);
          acc   <= '0;
          k     <= k + 1'b1;
          state <= S_TX;
        end
        S_DPREP: begin
          dneg  <= det[mi4_pkg::DET_W-1];
          dmag  <= det[mi4_pkg::DET_W-1] ? mi4_pkg::DET_W'(-det) : det;
          dzero <= (det == '0);
          state <= S_DRD;
        end
        S_DRD: state <= S_DST;
        S_DST: begin
          rneg <= av[mi4_pkg::ADJ_W-1] ^ dneg;
          if (dzero) begin
            m_tdata  <= mi4_pkg::TDATA_W'({k, {EW{1'b0}}});
            m_tuser  <= 2'b01;
            m_tlast  <= (k == IW'(mi4_pkg::MAT_DEPTH - 1));
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end else begin
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_res.done) begin
            m_tdata  <= mi4_pkg::TDATA_W'({k, rneg ? EW'(-qv) : qv});
            m_tuser  <= {sat, 1'b0};
            m_tlast  <= (k == IW'(mi4_pkg::MAT_DEPTH - 1));
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (k == IW'(mi4_pkg::MAT_DEPTH - 1)) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_DRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no loading while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input taken while a result is pending");

  // a singular result is zero and never clipped
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> ((m_tdata[EW-1:0] == '0) && !m_tuser[1]))
    else $error("singular result not zero");

  // the final result carries the last index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[EW +: IW] == IW'(mi4_pkg::MAT_DEPTH - 1)))
    else $error("last flag on wrong index");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DWAIT)) else $error("divider finished out of turn");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the 4x4 fixed point matrix inverter. Matrices are streamed in
// element by element; each index-15 transaction is predicted in exact wide
// integer arithmetic and the 16 inverse elements are checked field by field
// against the output stream, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH;
  localparam int FRAC_BITS  = mi4_pkg::FRAC_BITS;
  localparam int MAT_DEPTH  = mi4_pkg::MAT_DEPTH;
  localparam int IDX_W      = mi4_pkg::IDX_W;
  localparam int TDATA_W    = mi4_pkg::TDATA_W;
  localparam int TUSER_W    = mi4_pkg::TUSER_W;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 330;
  localparam int QUIET_AFTER = 290;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic signed [ELEM_WIDTH-1:0] value;
    logic [IDX_W-1:0]             index;
    logic                         singular;
    logic                         saturated;
    logic                         last;
  } inv_elem_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic [TUSER_W-1:0]   m_tuser;
  logic                 m_tlast;

  logic signed [ELEM_WIDTH-1:0] shadow_mat [MAT_DEPTH];
  inv_elem_t                    inverse_q[$];
  int                           errors = 0;
  int                           sent = 0;
  int                           cycles = 0;
  bit                           quiet = 1'b0;

  matrix4_inverse DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  // clock, 20 ns
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic wide_t ent(input int r, input int c);
    return wide_t'(shadow_mat[((r & 3) << 2) | (c & 3)]);
  endfunction

  // 3x3 determinant with row sr and column sc struck out
  function automatic wide_t minor3(input int sr, input int sc);
    int    rr[3];
    int    cc[3];
    int    n;
    int    m;
    wide_t t;
    wide_t acc;
    n = 0;
    m = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != sr) begin rr[n] = i; n++; end
      if (i != sc) begin cc[m] = i; m++; end
    end
    t = ent(rr[1], cc[1]) * ent(rr[2], cc[2]) - ent(rr[1], cc[2]) * ent(rr[2], cc[1]);
    acc = t * ent(rr[0], cc[0]);
    t = ent(rr[1], cc[0]) * ent(rr[2], cc[2]) - ent(rr[1], cc[2]) * ent(rr[2], cc[0]);
    acc = acc - t * ent(rr[0], cc[1]);
    t = ent(rr[1], cc[0]) * ent(rr[2], cc[1]) - ent(rr[1], cc[1]) * ent(rr[2], cc[0]);
    return acc + t * ent(rr[0], cc[2]);
  endfunction

  task automatic predict_inverse();
    wide_t     adj [16];
    wide_t     det;
    wide_t     dmag;
    wide_t     num;
    wide_t     quo;
    wide_t     lim;
    bit        rneg;
    inv_elem_t e;
    det = '0;
    for (int k = 0; k < 16; k++) begin
      adj[k] = minor3(k & 3, k >> 2);
      if (((k >> 2) + (k & 3)) & 1) adj[k] = -adj[k];
    end
    for (int k = 0; k < 4; k++) det = det + adj[k << 2] * ent(0, k);
    dmag = (det < 0) ? -det : det;
    for (int k = 0; k < 16; k++) begin
      e.index = IDX_W'(k);
      e.last = (k == 15);
      e.singular = (det == 0);
      e.saturated = 1'b0;
      e.value = '0;
      if (det != 0) begin
        rneg = (adj[k] < 0) != (det < 0);
        num = ((adj[k] < 0) ? -adj[k] : adj[k]) <<< (2 * FRAC_BITS);
        // nearest, ties away from zero
        quo = (2 * num + dmag) / (2 * dmag);
        lim = rneg ? (wide_t'(1) <<< (ELEM_WIDTH - 1))
                   : (wide_t'(1) <<< (ELEM_WIDTH - 1)) - 1;
        if (quo > lim) begin
          quo = lim;
          e.saturated = 1'b1;
        end
        e.value = rneg ? -quo[ELEM_WIDTH-1:0] : quo[ELEM_WIDTH-1:0];
      end
      inverse_q.push_back(e);
    end
  endtask

  // ------------------------------------------------------------------ sending
  task automatic send_element(input logic signed [ELEM_WIDTH-1:0] v, input int idx);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= TDATA_W'({IDX_W'(idx), v});
    do @(posedge clk); while (!s_tready);
    sent++;
    if (sent > QUIET_AFTER) quiet = 1'b1;
    shadow_mat[idx] = v;
    if (idx == 15) predict_inverse();
  endtask

  // output stall bursts
  always @(posedge clk) begin
    if (quiet || $urandom_range(0, 2) != 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
      m_tready <= 1'b1;
    end
  end

  // ----------------------------------------------------------------- checking
  always @(posedge clk) begin
    inv_elem_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (inverse_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = inverse_q.pop_front();
        if (m_tdata[ELEM_WIDTH-1:0] !== e.value)
          report($sformatf("idx %0d value %0d, expected %0d", e.index,
                 $signed(m_tdata[ELEM_WIDTH-1:0]), e.value));
        if (m_tdata[ELEM_WIDTH +: IDX_W] !== e.index)
          report($sformatf("index %0d, expected %0d", m_tdata[ELEM_WIDTH +: IDX_W], e.index));
        if (m_tuser[0] !== e.singular)
          report($sformatf("idx %0d singular %b, expected %b", e.index, m_tuser[0], e.singular));
        if (m_tuser[1] !== e.saturated)
          report($sformatf("idx %0d saturated %b, expected %b", e.index, m_tuser[1], e.saturated));
        if (m_tlast !== e.last)
          report($sformatf("idx %0d last %b, expected %b", e.index, m_tlast, e.last));
      end
    end
  end

  // -------------------------------------------------------------------- tests
  function automatic logic signed [ELEM_WIDTH-1:0] rand_elem(input int mode, input bit diag);
    case (mode)
      0: begin
        return ELEM_WIDTH'($urandom);
      end
      1: begin
        return ELEM_WIDTH'($urandom_range(0, 1024)) - 16'sd512;
      end
      default: begin
        if (diag)
          return ELEM_WIDTH'(($urandom_range(0, 1) ? 1 : -1) *
                             $signed(ELEM_WIDTH'($urandom_range(256, 32767))));
        return ELEM_WIDTH'($urandom_range(0, 256)) - 16'sd128;
      end
    endcase
  endfunction

  task automatic load_matrix(input int mode);
    int order [15];
    int j;
    int t;
    for (int i = 0; i < 15; i++) order[i] = i;
    for (int i = 14; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < 15; i++)
      send_element(rand_elem(mode, (order[i] % 5) == 0), order[i]);
    send_element(rand_elem(mode, 1'b1), 15);
  endtask

  task automatic test_identity();
    for (int i = 0; i < 16; i++) send_element((i % 5 == 0) ? 16'sd256 : 16'sd0, i);
  endtask

  // zero determinant
  task automatic test_singular();
    send_element(16'sd0, 15);
  endtask

  // extreme diagonals: most negative, most positive, tiny (saturating both ways)
  task automatic test_extremes();
    send_element(-16'sd32768, 15);
    send_element(16'sd32767, 15);
    for (int i = 0; i < 3; i++) send_element(16'sd1, i * 5);
    send_element(16'sd1, 15);
    send_element(-16'sd1, 15);
  endtask

  task automatic test_random();
    int pick;
    int n;
    while (sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        load_matrix($urandom_range(0, 2));
      end else if (pick < 17) begin
        // partial update then invert again
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_element(rand_elem(0, 1'b0), $urandom_range(0, 14));
        send_element(rand_elem($urandom_range(0, 2), 1'b1), 15);
      end else begin
        send_element(rand_elem(0, 1'b0), $urandom_range(0, 15));
      end
    end
  endtask

  task automatic test_drain();
    s_tvalid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity();
    test_singular();
    test_extremes();
    test_random();
    test_drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
